// ===== hdl/ppdi_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the pulse peak, decay time and integral block.
// Depends on nothing; every other file of the block imports it.
package ppdi_pkg;

  localparam int HALF_WINDOW_DEF = 10;
  localparam int MAX_RECORD_DEF  = 4096;

  localparam int SAMPLE_W    = 16;
  localparam int TIME_W      = 32;
  localparam int DECAY_W     = 33;
  localparam int INTEG_W     = 62;
  localparam int PAIR_SUM_W  = SAMPLE_W + 1;
  localparam int DELTA_T_W   = TIME_W + 1;
  localparam int TRAP_PROD_W = PAIR_SUM_W + DELTA_T_W;

  // 1/e in Q16, and the matching shift for the other side of the compare.
  localparam int INV_E_Q16 = 24109;
  localparam int Q16_SHIFT = 16;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;

  // Per-item position flags, worked out once from the sample counter and the end flag.
  typedef struct packed {
    logic first;         // first sample of a record
    logic rec_end;       // last sample of a record
    logic sub_old;       // the oldest window sample leaves the sum
    logic center;        // a full window exists, so this item has a center
    logic first_center;  // the first full window of the record
    logic short_rec;     // the record is no longer than one window so far
  } ppdi_flags_t;

endpackage

// ===== hdl/pulse_peak_decay_integral.sv =====
`timescale 1ns / 1ps
// Top level of the pulse peak, moving-average peak, decay time and integral block.
// Depends on ppdi_pkg for field widths, the 1/e constant and the item flag struct.

// One waveform record streams in, one sample item per cycle, and one result item
// comes out after the record's last sample (or after MAX_RECORD samples). The block
// takes a new item in every cycle; a sample passes three stages (input register,
// window sum and trapezoid product, peak and crossing decision), and a result then
// takes two more stages for the divide of the peak window sum by the window length,
// and the output register then holds the result for the receiver. The input is
// stalled only while a finished result sits in the last stage and the output
// register still holds an earlier result that the receiver stalls; the whole
// pipeline holds in that case. While the receiver stalls a held result and no
// second result is waiting behind it, samples keep flowing. The moving average is
// compared as window sums, and the fall below peak/e is tested as
// sum * 2^16 < ref * 24109, where the scaled reference is kept in a register so
// that no multiplier sits in the per-item decision loop. The polarity register is
// written through its own valid/ready port, which is always ready; write it only
// while the block is idle.
module pulse_peak_decay_integral #(
  parameter int HALF_WINDOW = ppdi_pkg::HALF_WINDOW_DEF,
  parameter int MAX_RECORD  = ppdi_pkg::MAX_RECORD_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration write port.
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic                                    cfg_invert_polarity_i,
  // Sample items.
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [ppdi_pkg::SAMPLE_W-1:0]    sample_value_i,
  input  logic signed [ppdi_pkg::TIME_W-1:0]      sample_time_i,
  input  logic                                    record_end_i,
  // Result items.
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [ppdi_pkg::SAMPLE_W-1:0]    max_sample_o,
  output logic signed [ppdi_pkg::SAMPLE_W-1:0]    avg_peak_o,
  output logic signed [ppdi_pkg::TIME_W-1:0]      peak_time_o,
  output logic signed [ppdi_pkg::DECAY_W-1:0]     decay_time_o,
  output logic signed [ppdi_pkg::INTEG_W-1:0]     integral_doubled_o,
  output logic                                    short_record_o
);
  import ppdi_pkg::*;

  localparam int WIN    = 2 * HALF_WINDOW + 1;
  localparam int TDEPTH = HALF_WINDOW + 1;
  // A window sum of WIN samples fits in SUM_W signed bits.
  localparam int SUM_W  = $clog2(WIN) + SAMPLE_W;
  localparam int SC_W   = SUM_W + Q16_SHIFT;
  localparam int CNT_W  = $clog2(MAX_RECORD);
  localparam int DIVM_W = SUM_W + 1;
  localparam int MUL_W  = SUM_W + DIVM_W;

  localparam logic signed [SUM_W-1:0] WinS   = SUM_W'(WIN);
  localparam logic signed [SC_W-1:0]  WinSc  = SC_W'(WIN);
  localparam logic signed [SC_W-1:0]  InvES  = SC_W'(INV_E_Q16);
  localparam logic [SUM_W:0]          WinU   = (SUM_W + 1)'(WIN);
  // Reciprocal of the window length; the estimate it gives is at most one low.
  localparam logic [DIVM_W-1:0]       DivM   = DIVM_W'((64'(1) << SUM_W) / WIN);

  // ---------------------------------------------------------------------------
  // Handshake and configuration
  // ---------------------------------------------------------------------------
  logic advance;
  logic in_acc;
  logic invert_q;

  logic s1_v_q, s2_v_q, s3_v_q, r1_v_q, r2_v_q;
  logic out_valid_q;

  // The whole pipeline moves together; it halts only when a result in the last
  // stage cannot be loaded into the output register.
  assign advance     = !(r2_v_q && out_valid_q && out_stall_i);
  assign in_stall_o  = !advance;
  assign in_acc      = in_valid_i && advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
    end else if (cfg_valid_i) begin
      invert_q <= cfg_invert_polarity_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: polarity, sample counter, trapezoid pair terms
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0]   x_in;
  logic signed [SAMPLE_W-1:0]   prev_x_q;
  logic signed [TIME_W-1:0]     prev_t_q;
  logic [CNT_W-1:0]             cnt_q;
  ppdi_flags_t                  flags_in;
  logic signed [PAIR_SUM_W-1:0] pair_sum;
  logic signed [DELTA_T_W-1:0]  delta_t;

  always_comb begin
    x_in = sample_value_i;
    if (invert_q) begin
      x_in = (sample_value_i == SAMPLE_MIN) ? SAMPLE_MAX : -sample_value_i;
    end
    flags_in.first        = (cnt_q == '0);
    flags_in.rec_end      = record_end_i || (32'(cnt_q) == MAX_RECORD - 1);
    flags_in.sub_old      = (32'(cnt_q) >= WIN);
    flags_in.center       = (32'(cnt_q) >= WIN - 1);
    flags_in.first_center = (32'(cnt_q) == WIN - 1);
    flags_in.short_rec    = (32'(cnt_q) <= WIN - 1);
    pair_sum = PAIR_SUM_W'(prev_x_q) + PAIR_SUM_W'(x_in);
    delta_t  = DELTA_T_W'(sample_time_i) - DELTA_T_W'(prev_t_q);
  end

  logic signed [SAMPLE_W-1:0]   s1_x_q;
  logic signed [TIME_W-1:0]     s1_t_q;
  logic signed [PAIR_SUM_W-1:0] s1_pair_q;
  logic signed [DELTA_T_W-1:0]  s1_dt_q;
  ppdi_flags_t                  s1_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      s1_v_q <= 1'b0;
    end else if (advance) begin
      s1_v_q <= in_valid_i;
      if (in_valid_i) begin
        cnt_q <= flags_in.rec_end ? '0 : cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prev_x_q <= x_in;
      prev_t_q <= sample_time_i;
    end
    if (advance) begin
      s1_x_q     <= x_in;
      s1_t_q     <= sample_time_i;
      s1_pair_q  <= pair_sum;
      s1_dt_q    <= delta_t;
      s1_flags_q <= flags_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sliding window sum, center-time delay line, trapezoid product
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] win_q [WIN];
  logic signed [TIME_W-1:0]   tdl_q [TDEPTH];
  logic signed [SUM_W-1:0]    sum_run_q;
  logic signed [SUM_W-1:0]    sum_new;

  // The oldest window entry is the sample WIN items back; it leaves the sum once
  // the window is full. The first sample of a record restarts the sum.
  always_comb begin
    sum_new = s1_flags_q.first ? '0 : sum_run_q;
    if (s1_flags_q.sub_old) begin
      sum_new = sum_new - SUM_W'(win_q[WIN-1]);
    end
    sum_new = sum_new + SUM_W'(s1_x_q);
  end

  logic signed [SAMPLE_W-1:0]    s2_x_q;
  logic signed [SUM_W-1:0]       s2_sum_q;
  logic signed [TRAP_PROD_W-1:0] s2_prod_q;
  ppdi_flags_t                   s2_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (advance) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_x_q     <= s1_x_q;
      s2_sum_q   <= sum_new;
      s2_prod_q  <= s1_pair_q * s1_dt_q;
      s2_flags_q <= s1_flags_q;
      if (s1_v_q) begin
        sum_run_q <= sum_new;
        win_q[0]  <= s1_x_q;
        for (int i = 1; i < WIN; i++) begin
          win_q[i] <= win_q[i-1];
        end
        tdl_q[0] <= s1_t_q;
        for (int i = 1; i < TDEPTH; i++) begin
          tdl_q[i] <= tdl_q[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 registers: scaled sum, center time; record scalars updated here
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] largest_q;
  logic signed [SAMPLE_W-1:0] first_val_q;
  logic signed [INTEG_W-1:0]  trap_q;

  logic signed [SUM_W-1:0]    s3_sum_q;
  logic signed [SC_W-1:0]     s3_psum_q;
  logic signed [TIME_W-1:0]   s3_ctime_q;
  ppdi_flags_t                s3_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (advance) begin
      s3_v_q <= s2_v_q;
    end
  end

  // The delay line already holds this item's time, so its last tap is the
  // time of the window center.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_sum_q   <= s2_sum_q;
      s3_psum_q  <= s2_sum_q * InvES;
      s3_ctime_q <= tdl_q[HALF_WINDOW];
      s3_flags_q <= s2_flags_q;
      if (s2_v_q) begin
        if (s2_flags_q.first) begin
          largest_q   <= s2_x_q;
          first_val_q <= s2_x_q;
          trap_q      <= '0;
        end else begin
          if (s2_x_q > largest_q) begin
            largest_q <= s2_x_q;
          end
          trap_q <= trap_q + INTEG_W'(s2_prod_q);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 decision: peak tracking and the 1/e crossing
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0]  ref_q, ref_d;
  logic signed [SC_W-1:0]   refsc_q, refsc_d;
  logic                     from_q, from_d;
  logic signed [TIME_W-1:0] best_t_q, best_t_d;
  logic                     cross_q, cross_d;
  logic signed [TIME_W-1:0] cross_t_q, cross_t_d;
  logic signed [SC_W-1:0]   sum_shift;
  logic                     beats_ref;

  // On the first sample the reference becomes WIN times that sample, which is
  // the sum a window of the first sample alone would have.
  always_comb begin
    ref_d     = s3_flags_q.first ? s3_sum_q * WinS : ref_q;
    refsc_d   = s3_flags_q.first ? s3_psum_q * WinSc : refsc_q;
    from_d    = s3_flags_q.first ? 1'b0 : from_q;
    best_t_d  = s3_flags_q.first ? '0 : best_t_q;
    cross_d   = s3_flags_q.first ? 1'b0 : cross_q;
    cross_t_d = cross_t_q;
    sum_shift = $signed({s3_sum_q, {Q16_SHIFT{1'b0}}});
    beats_ref = (s3_sum_q > ref_d);
    if (s3_flags_q.center) begin
      if (s3_flags_q.first_center) begin
        best_t_d = s3_ctime_q;
        if (beats_ref) begin
          ref_d   = s3_sum_q;
          refsc_d = s3_psum_q;
          from_d  = 1'b1;
        end
      end else if (beats_ref) begin
        ref_d    = s3_sum_q;
        refsc_d  = s3_psum_q;
        from_d   = 1'b1;
        best_t_d = s3_ctime_q;
        cross_d  = 1'b0;
      end else if (!cross_d && (sum_shift < refsc_d)) begin
        cross_d   = 1'b1;
        cross_t_d = s3_ctime_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s3_v_q) begin
      ref_q     <= ref_d;
      refsc_q   <= refsc_d;
      from_q    <= from_d;
      best_t_q  <= best_t_d;
      cross_q   <= cross_d;
      cross_t_q <= cross_t_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result stages: divide the peak sum by WIN, then the output register
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]           ref_abs;
  logic signed [TIME_W-1:0]   end_t;

  assign ref_abs = ref_d[SUM_W-1] ? SUM_W'(-ref_d) : SUM_W'(ref_d);
  assign end_t   = cross_d ? cross_t_d : s3_ctime_q;

  logic signed [SAMPLE_W-1:0] r1_max_q, r2_max_q;
  logic signed [SAMPLE_W-1:0] r1_first_q, r2_first_q;
  logic                       r1_from_q, r2_from_q;
  logic [SUM_W-1:0]           r1_abs_q, r2_abs_q;
  logic                       r1_neg_q, r2_neg_q;
  logic signed [TIME_W-1:0]   r1_ptime_q, r2_ptime_q;
  logic signed [DECAY_W-1:0]  r1_decay_q, r2_decay_q;
  logic signed [INTEG_W-1:0]  r1_trap_q, r2_trap_q;
  logic                       r1_short_q, r2_short_q;
  logic [MUL_W-1:0]           r2_mul_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
    end else if (advance) begin
      r1_v_q <= s3_v_q && s3_flags_q.rec_end;
      r2_v_q <= r1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      r1_max_q   <= largest_q;
      r1_first_q <= first_val_q;
      r1_from_q  <= from_d;
      r1_abs_q   <= ref_abs;
      r1_neg_q   <= ref_d[SUM_W-1];
      r1_ptime_q <= s3_flags_q.center ? best_t_d : '0;
      r1_decay_q <= s3_flags_q.center ? DECAY_W'(end_t) - DECAY_W'(best_t_d) : '0;
      r1_trap_q  <= trap_q;
      r1_short_q <= s3_flags_q.short_rec;

      r2_max_q   <= r1_max_q;
      r2_first_q <= r1_first_q;
      r2_from_q  <= r1_from_q;
      r2_abs_q   <= r1_abs_q;
      r2_neg_q   <= r1_neg_q;
      r2_ptime_q <= r1_ptime_q;
      r2_decay_q <= r1_decay_q;
      r2_trap_q  <= r1_trap_q;
      r2_short_q <= r1_short_q;
      r2_mul_q   <= MUL_W'(r1_abs_q) * MUL_W'(DivM);
    end
  end

  // The reciprocal estimate is exact or one low; one remainder compare fixes it.
  logic [SUM_W:0]             div_est;
  logic [SUM_W:0]             div_rem;
  logic [SUM_W:0]             div_quo;
  logic [SUM_W:0]             div_signed;
  logic signed [SAMPLE_W-1:0] avg_d;

  always_comb begin
    div_est    = r2_mul_q[MUL_W-1:SUM_W];
    div_rem    = {1'b0, r2_abs_q} - (div_est * WinU);
    div_quo    = div_est + (SUM_W + 1)'(div_rem >= WinU);
    div_signed = r2_neg_q ? -div_quo : div_quo;
    avg_d      = r2_from_q ? $signed(div_signed[SAMPLE_W-1:0]) : r2_first_q;
  end

  logic signed [SAMPLE_W-1:0] out_max_q, out_avg_q;
  logic signed [TIME_W-1:0]   out_ptime_q;
  logic signed [DECAY_W-1:0]  out_decay_q;
  logic signed [INTEG_W-1:0]  out_trap_q;
  logic                       out_short_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (r2_v_q && advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2_v_q && advance) begin
      out_max_q   <= r2_max_q;
      out_avg_q   <= avg_d;
      out_ptime_q <= r2_ptime_q;
      out_decay_q <= r2_decay_q;
      out_trap_q  <= r2_trap_q;
      out_short_q <= r2_short_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign max_sample_o       = out_max_q;
  assign avg_peak_o         = out_avg_q;
  assign peak_time_o        = out_ptime_q;
  assign decay_time_o       = out_decay_q;
  assign integral_doubled_o = out_trap_q;
  assign short_record_o     = out_short_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_needs_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_result_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r2_v_q && !advance) |=> r2_v_q)
    else $error("pending result lost while output was held");

  a_end_makes_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && s3_flags_q.rec_end && advance) |=> r1_v_q)
    else $error("record end did not start a result");

  a_first_restarts_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && s3_flags_q.first && advance) |=> (!cross_q && !from_q))
    else $error("first sample did not restart peak tracking");

endmodule

// ===== test/tb_pulse_peak_decay_integral.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pulse_peak_decay_integral: waveform records stream in and
// a bit-exact predictor builds the expected result items that a checker compares against.
// Depends on ppdi_pkg and the RTL of the block.
module tb_pulse_peak_decay_integral;
  import ppdi_pkg::*;

  localparam int WIN            = 2 * HALF_WINDOW_DEF + 1;
  localparam int TAPS           = HALF_WINDOW_DEF + 1;
  // The longest correct quiet stretch is the long receiver hold-off plus random stalls,
  // so a quiet stretch that reaches the limit means the block is hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Idle time that lets every sample still in the pipeline clear out.
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 370;
  localparam int PHASE_RECORDS  = 12;

  typedef enum int {SHAPE_NOISE, SHAPE_PULSE, SHAPE_RAMP, SHAPE_FLAT} shape_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] max_sample;
    logic signed [SAMPLE_W-1:0] avg_peak;
    logic signed [TIME_W-1:0]   peak_time;
    logic signed [DECAY_W-1:0]  decay_time;
    logic signed [INTEG_W-1:0]  integral_doubled;
    logic                       short_record;
  } pulse_result_t;

  // Stimulus side of the block. Every input has a known value from time zero.
  logic                       clk_i                 = 1'b0;
  logic                       rst_ni                = 1'b0;
  logic                       cfg_valid_i           = 1'b0;
  logic                       cfg_ready_o;
  logic                       cfg_invert_polarity_i = 1'b0;
  logic                       in_valid_i            = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_value_i        = '0;
  logic signed [TIME_W-1:0]   sample_time_i         = '0;
  logic                       record_end_i          = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i           = 1'b0;
  logic signed [SAMPLE_W-1:0] max_sample_o;
  logic signed [SAMPLE_W-1:0] avg_peak_o;
  logic signed [TIME_W-1:0]   peak_time_o;
  logic signed [DECAY_W-1:0]  decay_time_o;
  logic signed [INTEG_W-1:0]  integral_doubled_o;
  logic                       short_record_o;

  // Idle rates in percent, set by each test; the receiver hold-off is requested by a test
  // and counted down by the receiver process itself.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;

  int fail_count      = 0;
  int items_sent      = 0;
  int results_checked = 0;

  pulse_result_t expected_results_q[$];

  // Predictor copy of the record state. Wide integer types keep every intermediate exact;
  // the doubled integral is accumulated in 64 bits and only its low 62 bits are compared.
  bit          pol_invert;
  int          ring_val [WIN];
  longint      ring_time[TAPS];
  longint      run_sum;
  longint      peak_sum;
  bit          peak_is_avg;
  longint      peak_ctime;
  bit          fall_seen;
  longint      fall_time;
  int          top_val;
  int          first_val;
  logic [63:0] area_acc;
  int          last_val;
  longint      last_time;
  int          rec_count;

  pulse_peak_decay_integral dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_invert_polarity_i(cfg_invert_polarity_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .sample_value_i       (sample_value_i),
    .sample_time_i        (sample_time_i),
    .record_end_i         (record_end_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .max_sample_o         (max_sample_o),
    .avg_peak_o           (avg_peak_o),
    .peak_time_o          (peak_time_o),
    .decay_time_o         (decay_time_o),
    .integral_doubled_o   (integral_doubled_o),
    .short_record_o       (short_record_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_record_state();
    foreach (ring_val[i]) ring_val[i] = 0;
    foreach (ring_time[i]) ring_time[i] = 0;
    run_sum     = 0;
    peak_sum    = 0;
    peak_is_avg = 1'b0;
    peak_ctime  = 0;
    fall_seen   = 1'b0;
    fall_time   = 0;
    top_val     = 0;
    first_val   = 0;
    area_acc    = '0;
    last_val    = 0;
    last_time   = 0;
    rec_count   = 0;
  endfunction

  // Advances the predictor by one accepted sample item and queues a result item when the
  // record closes, either by its end flag or by reaching the maximum record length.
  function automatic void predict_sample(input logic signed [SAMPLE_W-1:0] raw,
                                         input logic signed [TIME_W-1:0] ts,
                                         input logic end_flag);
    int            k;
    int            x;
    int            slot;
    longint        t;
    longint        ctime;
    longint        ref_sum;
    longint        avg;
    longint        ptime;
    longint        decay;
    bit            closes;
    bit            has_center;
    pulse_result_t r;
    k          = rec_count;
    x          = raw;
    t          = ts;
    closes     = end_flag || (k + 1 >= MAX_RECORD_DEF);
    ctime      = 0;
    has_center = 1'b0;

    // Negation saturates, since +32768 has no 16-bit code.
    if (pol_invert) begin
      x = (x == -32768) ? 32767 : -x;
    end

    if (k == 0) begin
      first_val = x;
      top_val   = x;
    end else begin
      if (x > top_val) begin
        top_val = x;
      end
      area_acc = area_acc + 64'(longint'(last_val + x) * (t - last_time));
    end
    last_val  = x;
    last_time = t;

    slot = k % WIN;
    if (k >= WIN) begin
      run_sum -= ring_val[slot];
    end
    ring_val[slot] = x;
    run_sum += x;
    ring_time[k % TAPS] = t;

    if (k >= WIN - 1) begin
      // Until some window beats it, the peak is the first sample scaled to a window sum.
      ref_sum    = peak_is_avg ? peak_sum : longint'(WIN) * first_val;
      has_center = 1'b1;
      ctime      = ring_time[(k - HALF_WINDOW_DEF) % TAPS];
      if (k == WIN - 1) begin
        peak_ctime = ctime;
        if (run_sum > ref_sum) begin
          peak_sum    = run_sum;
          peak_is_avg = 1'b1;
        end
      end else if (run_sum > ref_sum) begin
        peak_sum    = run_sum;
        peak_is_avg = 1'b1;
        peak_ctime  = ctime;
        fall_seen   = 1'b0;
      end else if (!fall_seen &&
                   (run_sum << Q16_SHIFT) < ref_sum * longint'(INV_E_Q16)) begin
        fall_seen = 1'b1;
        fall_time = ctime;
      end
    end
    rec_count = k + 1;

    if (closes) begin
      avg   = peak_is_avg ? peak_sum / WIN : longint'(first_val);
      ptime = has_center ? peak_ctime : 0;
      decay = has_center ? (fall_seen ? fall_time : ctime) - peak_ctime : 0;
      r.max_sample       = top_val[SAMPLE_W-1:0];
      r.avg_peak         = avg[SAMPLE_W-1:0];
      r.peak_time        = ptime[TIME_W-1:0];
      r.decay_time       = decay[DECAY_W-1:0];
      r.integral_doubled = area_acc[INTEG_W-1:0];
      r.short_record     = (k + 1 <= WIN);
      expected_results_q = {expected_results_q, r};
      clear_record_state();
    end
  endfunction

  // Offers one sample item, with a random idle gap first, and holds it until accepted.
  // The stall is sampled at the falling edge, where everything driven at the rising edge
  // has settled, so the decision does not depend on event order within a time step.
  task automatic send_item(input logic signed [SAMPLE_W-1:0] value,
                           input logic signed [TIME_W-1:0] ts,
                           input logic last);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= value;
    sample_time_i  <= ts;
    record_end_i   <= last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    predict_sample(value, ts, last);
    items_sent++;
  endtask

  // Builds one record of the given length and waveform shape. Most records look like
  // real pulses so that peaks move and the fall below peak/e gets found; rising ramps put
  // the peak on the last center, flat records with a high first sample keep the peak on the
  // first sample, and noise records hit every bit of the sample field.
  task automatic send_record(input int len, input shape_e shape);
    int                       base;
    int                       amp;
    int                       tau;
    int                       start;
    int                       level;
    int                       slope;
    int                       v;
    int                       i;
    logic signed [TIME_W-1:0] ts;
    bit                       wild;
    base  = int'($urandom_range(600)) - 300;
    amp   = int'($urandom_range(32000, 200));
    if ($urandom_range(1) == 1) begin
      amp = -amp;
    end
    tau   = int'($urandom_range(40, 2));
    start = int'($urandom_range(len / 3));
    slope = int'($urandom_range(1500)) - 300;
    ts    = $urandom;
    wild  = ($urandom_range(7) == 0);
    level = 0;
    for (i = 0; i < len; i++) begin
      case (shape)
        SHAPE_NOISE: v = int'($urandom_range(65535)) - 32768;
        SHAPE_PULSE: begin
          if (i == start) begin
            level = amp;
          end else if (i > start) begin
            level = level - level / tau;
          end
          v = base + level + int'($urandom_range(40)) - 20;
        end
        SHAPE_RAMP: v = base + i * slope;
        default: v = (i == 0) ? base + 2000 : base;
      endcase
      if (v > 32767) begin
        v = 32767;
      end else if (v < -32768) begin
        v = -32768;
      end
      send_item(SAMPLE_W'(v), ts, i == len - 1);
      ts = wild ? TIME_W'($urandom) : ts + TIME_W'($urandom_range(2000));
    end
  endtask

  // Drops the input valid and waits until every expected result item has arrived.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // The polarity register is only written while the block is empty; the settle time
  // lets any sample still in the pipeline clear out before the write.
  task automatic write_polarity(input logic value);
    bit taken;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i           <= 1'b1;
    cfg_invert_polarity_i <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    pol_invert = value;
  endtask

  task automatic test_single_sample();
    // A record of one sample has no full window: no peak time and no decay.
    send_item(SAMPLE_MIN, 32'sh7fff_ffff, 1'b1);
  endtask

  task automatic test_full_window_ramp();
    int i;
    // Exactly one window, rising from the lowest code, with timestamps that wrap past
    // the largest positive value. The only center is also the last one.
    for (i = 0; i < WIN; i++) begin
      send_item(SAMPLE_W'(-32768 + i * 3276), TIME_W'(32'h7fff_fff6 + i), i == WIN - 1);
    end
  endtask

  task automatic test_invert_saturation();
    write_polarity(1'b1);
    // The lowest code saturates to the highest one when negated.
    send_item(SAMPLE_MIN, 32'sh0000_0000, 1'b0);
    send_item(SAMPLE_MAX, 32'sh0000_0005, 1'b0);
    send_item(16'sh0000, 32'sh8000_0000, 1'b1);
  endtask

  task automatic test_random_phase(input int sender_pct, input int receiver_pct,
                                   input logic polarity);
    int     sent;
    int     recs;
    int     len;
    int     pick;
    shape_e shape;
    write_polarity(polarity);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    sent = 0;
    recs = 0;
    while (sent < PHASE_ITEMS || recs < PHASE_RECORDS) begin
      pick = int'($urandom_range(99));
      if (pick < 15) begin
        len = int'($urandom_range(20, 1));
      end else if (pick < 30) begin
        len = int'($urandom_range(23, 20));
      end else if (pick < 96) begin
        len = int'($urandom_range(60, 22));
      end else begin
        len = int'($urandom_range(250, 100));
      end
      pick = int'($urandom_range(99));
      if (pick < 10) begin
        shape = SHAPE_NOISE;
      end else if (pick < 70) begin
        shape = SHAPE_PULSE;
      end else if (pick < 85) begin
        shape = SHAPE_RAMP;
      end else begin
        shape = SHAPE_FLAT;
      end
      send_record(len, shape);
      sent += len;
      recs++;
    end
  endtask

  task automatic test_overlong_record();
    int i;
    write_polarity(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // No end flag at all: the block must close the record on its own at the maximum
    // length. Full-scale samples against full-range time swings drive the integral
    // toward its largest reachable magnitude.
    for (i = 0; i < MAX_RECORD_DEF; i++) begin
      send_item((i % 4 < 2) ? SAMPLE_MAX : -SAMPLE_MAX,
                (i % 4 == 1 || i % 4 == 2) ? 32'sh7fff_ffff : 32'sh8000_0000, 1'b0);
    end
    // The next record must start from a clean state.
    send_item(16'sh0123, 32'sh0000_0010, 1'b0);
    send_item(16'sh7abc, 32'sh0000_0020, 1'b1);
  endtask

  task automatic test_output_holdoff();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // The receiver stalls for a long stretch while short records keep coming, so the
    // block backs up and has to stall its input.
    hold_req = 1'b1;
    for (i = 0; i < 40; i++) begin
      send_record(2, SHAPE_NOISE);
    end
  endtask

  task automatic test_drain_pause();
    int i;
    send_idle_pct = 10;
    recv_idle_pct = 30;
    for (i = 0; i < 6; i++) begin
      send_record(int'($urandom_range(30, 1)), SHAPE_PULSE);
    end
    // The sender goes quiet until every result has come back, then starts again.
    drain_results();
    for (i = 0; i < 6; i++) begin
      send_record(int'($urandom_range(30, 1)), SHAPE_PULSE);
    end
  endtask

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Result checker: sampled at the falling edge, when the handshake signals are stable.
  always @(negedge clk_i) begin : result_check
    pulse_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results_q.size() == 0) begin
        $display("%0t ns: result item with no expected item waiting", $time);
        fail_count++;
      end else begin
        exp_r = expected_results_q.pop_front();
        compare_field("max_sample", exp_r.max_sample, max_sample_o);
        compare_field("avg_peak", exp_r.avg_peak, avg_peak_o);
        compare_field("peak_time", exp_r.peak_time, peak_time_o);
        compare_field("decay_time", exp_r.decay_time, decay_time_o);
        compare_field("integral_doubled", exp_r.integral_doubled, integral_doubled_o);
        compare_field("short_record", exp_r.short_record, short_record_o);
      end
      results_checked++;
    end
  end

  // Watchdog: ends the run when no item has moved on any port for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    pol_invert = 1'b0;
    clear_record_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 23;
    recv_idle_pct = 87;
    write_polarity(1'b0);
    test_single_sample();
    test_full_window_ramp();
    test_invert_saturation();

    test_random_phase(23, 87, 1'b1);
    test_random_phase(87, 23, 1'b0);
    test_random_phase(0, 0, 1'b1);

    test_overlong_record();
    test_output_holdoff();
    test_drain_pause();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results_q.size() != 0) begin
      $display("%0t ns: %0d expected result items never arrived", $time,
               expected_results_q.size());
      fail_count++;
    end
    $display("Covered %0d sample items and %0d result items over both polarities,", items_sent,
             results_checked);
    $display("three idle mixes, a long output hold-off and a record closed by length.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
